FILE: hdl/msli_pkg.sv
// shared types and constants of the multi servo linear interpolator
package msli_pkg;

   localparam int NUM_CH  = 4;
   localparam int CH_W    = 2;
   localparam int ANGLE_W = 8;
   localparam int TGT_W   = 9;
   localparam int CMD_W   = 2;

   localparam int CH_SHOULDER = 0;
   localparam int CH_ELBOW    = 1;
   localparam int CH_WRIST    = 2;
   localparam int CH_GRIP     = 3;

   localparam logic [ANGLE_W-1:0] RESET_ANGLE = 8'd90;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_MOVE  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

endpackage

FILE: hdl/msli_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module msli_div #(
   parameter int DVS_W = 16,
   parameter int SH_W  = 16,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] iter_count,
   input  logic [DVS_W-1:0] rem_init,
   input  logic [SH_W-1:0]  bits_in,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [SH_W-1:0]  quotient
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [SH_W-1:0]  q_ff, q_in;
   logic [DVS_W:0]   rem_t;
   logic [DVS_W:0]   diff;
   logic             ge;

   // rem_ff stays below the divisor, so the trial value fits one extra bit
   assign rem_t = {rem_ff, sh_ff[SH_W-1]};
   assign ge    = rem_t >= {1'b0, dvs_ff};
   assign diff  = rem_t - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iter_count;
         rem_in  = rem_init;
         dvs_in  = divisor;
         sh_in   = bits_in;
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : rem_t[DVS_W-1:0];
         sh_in  = {sh_ff[SH_W-2:0], 1'b0};
         q_in   = {q_ff[SH_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

FILE: hdl/multi_servo_linear_interpolator.sv
// top level of the four channel servo angle interpolator
// Four servo channels (shoulder, elbow, wrist, grip) are moved in straight lines from their
// current angles to new targets. A start transaction latches the current angles, takes the
// targets of the enabled channels and sets the step count to duration_ms / TICK_MS; every
// later tick transaction advances one step and each enabled channel goes to
// start - ((start - target) * i) / steps, truncated toward zero. Shoulder is enabled for a
// target of 0 or more, the other channels for a target above 0. A zero step count jumps
// straight to the targets. An immediate move sets the angles at once (grip only for a
// target above 0) and cancels any motion. Each request transaction gives exactly one
// response transaction. The step count comes from a reciprocal multiply of the duration
// at the accepting edge. One serial divider, producing one quotient bit per cycle, does the
// interpolation division, and the block takes no new request while it works: a start passes
// the sizing state, a tick the multiply, load and divide states per enabled channel
// (only multiply if disabled), and each request ends in the output state. A stalled response
// holds the sequencer in its output state for as long as the stall lasts. A finished
// response waits in the output register, so a new request is taken while it is stalled.
module multi_servo_linear_interpolator #(
   parameter int TICK_MS       = 10,
   parameter int DURATION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [msli_pkg::CMD_W-1:0]             req_cmd,
   input  logic signed [msli_pkg::TGT_W-1:0]      req_target_shoulder,
   input  logic signed [msli_pkg::TGT_W-1:0]      req_target_elbow,
   input  logic signed [msli_pkg::TGT_W-1:0]      req_target_wrist,
   input  logic signed [msli_pkg::TGT_W-1:0]      req_target_grip,
   input  logic [DURATION_BITS-1:0]               req_duration_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [msli_pkg::ANGLE_W-1:0]           rsp_angle_shoulder,
   output logic [msli_pkg::ANGLE_W-1:0]           rsp_angle_elbow,
   output logic [msli_pkg::ANGLE_W-1:0]           rsp_angle_wrist,
   output logic [msli_pkg::ANGLE_W-1:0]           rsp_angle_grip,
   output logic                                   rsp_moving,
   output logic                                   rsp_finished
);

   import msli_pkg::*;

   // step count never exceeds duration, so it fits DURATION_BITS
   localparam int DB        = DURATION_BITS;
   localparam int CNT_W     = $clog2(ANGLE_W + 1);
   localparam int PROD_W    = ANGLE_W + DB;
   localparam int LOW_SHIFT = DB - ANGLE_W;

   // duration / TICK_MS as a reciprocal multiply: M = ceil(2^S / TICK_MS) with
   // S = DB + ceil(log2 TICK_MS) is exact for every DB-bit duration
   localparam int     RECIP_S = DB + $clog2(TICK_MS);
   localparam int     RECIP_W = DB + 2;
   localparam int     DPROD_W = DB + RECIP_W;
   localparam longint RECIP_M = ((longint'(1) << RECIP_S) + longint'(TICK_MS) - 1)
                                / longint'(TICK_MS);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_STEPS = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // channel state
   logic [ANGLE_W-1:0] servo_ff [NUM_CH];
   logic [ANGLE_W-1:0] servo_in [NUM_CH];
   logic [ANGLE_W-1:0] start_ff [NUM_CH];
   logic [ANGLE_W-1:0] start_in [NUM_CH];
   logic [ANGLE_W-1:0] goal_ff  [NUM_CH];
   logic [ANGLE_W-1:0] goal_in  [NUM_CH];
   logic [NUM_CH-1:0]  enable_ff, enable_in;
   logic [DB-1:0]      total_ff, total_in;
   logic [DB-1:0]      idx_ff, idx_in;
   logic               active_ff, active_in;
   logic               fin_ff, fin_in;
   logic [CH_W-1:0]    ch_ff, ch_in;

   // per channel arithmetic
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic [ANGLE_W-1:0] mag;
   logic [ANGLE_W-1:0] q_mag;

   // step count of a start transaction
   logic [DPROD_W-1:0] dur_prod;
   logic [DB-1:0]      dur_steps;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0] rsp_angle_ff [NUM_CH];
   logic [ANGLE_W-1:0] rsp_angle_in [NUM_CH];
   logic               rsp_moving_ff, rsp_moving_in;
   logic               rsp_fin_ff, rsp_fin_in;

   // request targets as a small array
   logic signed [TGT_W-1:0] tgt [NUM_CH];
   logic [NUM_CH-1:0]       tgt_en;

   // divider hookup
   logic                div_start;
   logic [CNT_W-1:0]    div_count;
   logic [DB-1:0]       div_rem_init;
   logic [DB-1:0]       div_bits;
   logic [DB-1:0]       div_divisor;
   logic                div_done;
   logic [DB-1:0]       div_q;
   logic                ch_done;

   assign tgt[CH_SHOULDER] = req_target_shoulder;
   assign tgt[CH_ELBOW]    = req_target_elbow;
   assign tgt[CH_WRIST]    = req_target_wrist;
   assign tgt[CH_GRIP]     = req_target_grip;

   // shoulder accepts zero, the others need a positive target
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         if (k == CH_SHOULDER) begin
            tgt_en[k] = ~tgt[k][TGT_W-1];
         end else begin
            tgt_en[k] = ~tgt[k][TGT_W-1] && (tgt[k] != '0);
         end
      end
   end

   // step count taken straight from the request at the accepting edge
   assign dur_prod  = DPROD_W'(req_duration_ms) * DPROD_W'(RECIP_M);
   assign dur_steps = DB'(dur_prod >> RECIP_S);

   // distance of the current channel and its quotient magnitude
   assign mag   = (start_ff[ch_ff] >= goal_ff[ch_ff]) ? start_ff[ch_ff] - goal_ff[ch_ff]
                                                     : goal_ff[ch_ff] - start_ff[ch_ff];
   assign q_mag = div_q[ANGLE_W-1:0];

   // interpolation divides |distance| * i by the step count, whose quotient fits
   // ANGLE_W bits, so the upper product bits preload the remainder
   assign div_count    = CNT_W'(ANGLE_W);
   assign div_rem_init = prod_ff[PROD_W-1:ANGLE_W];
   assign div_bits     = DB'(prod_ff[ANGLE_W-1:0]) << LOW_SHIFT;
   assign div_divisor  = total_ff;

   msli_div #(
      .DVS_W (DB),
      .SH_W  (DB),
      .CNT_W (CNT_W)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .iter_count (div_count),
      .rem_init   (div_rem_init),
      .bits_in    (div_bits),
      .divisor    (div_divisor),
      .done       (div_done),
      .quotient   (div_q)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      servo_in      = servo_ff;
      start_in      = start_ff;
      goal_in       = goal_ff;
      enable_in     = enable_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      fin_in        = fin_ff;
      ch_in         = ch_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_angle_in  = rsp_angle_ff;
      rsp_moving_in = rsp_moving_ff;
      rsp_fin_in    = rsp_fin_ff;
      div_start     = 1'b0;
      ch_done       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_in = 1'b0;
               unique case (req_cmd)
                  CMD_START: begin
                     // latch start points and goals, then size the move
                     for (int k = 0; k < NUM_CH; k++) begin
                        start_in[k] = servo_ff[k];
                        if (tgt_en[k]) begin
                           goal_in[k] = tgt[k][ANGLE_W-1:0];
                        end
                     end
                     enable_in = tgt_en;
                     total_in  = dur_steps;
                     idx_in    = '0;
                     state_in  = ST_STEPS;
                  end
                  CMD_TICK: begin
                     if (active_ff && (total_ff != '0) && (idx_ff < total_ff)) begin
                        idx_in   = idx_ff + 1'b1;
                        ch_in    = '0;
                        state_in = ST_MUL;
                     end else begin
                        active_in = 1'b0;
                        state_in  = ST_OUT;
                     end
                  end
                  CMD_MOVE: begin
                     // negative targets land as zero; grip only moves for a positive one
                     for (int k = 0; k < NUM_CH; k++) begin
                        if (k != CH_GRIP || tgt_en[k]) begin
                           servo_in[k] = tgt[k][TGT_W-1] ? '0 : tgt[k][ANGLE_W-1:0];
                        end
                     end
                     active_in = 1'b0;
                     state_in  = ST_OUT;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_STEPS: begin
            if (total_ff == '0) begin
               // no steps: jump to the goals right away
               for (int k = 0; k < NUM_CH; k++) begin
                  if (enable_ff[k]) begin
                     servo_in[k] = goal_ff[k];
                  end
               end
               active_in = 1'b0;
               fin_in    = 1'b1;
            end else begin
               active_in = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_MUL: begin
            if (enable_ff[ch_ff]) begin
               prod_in  = PROD_W'(mag) * PROD_W'(idx_ff);
               neg_in   = start_ff[ch_ff] < goal_ff[ch_ff];
               state_in = ST_LOAD;
            end else begin
               ch_done = 1'b1;
            end
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               // moving up when the goal lies above the start
               servo_in[ch_ff] = neg_ff ? start_ff[ch_ff] + q_mag : start_ff[ch_ff] - q_mag;
               ch_done         = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_angle_in  = servo_ff;
               rsp_moving_in = active_ff;
               rsp_fin_in    = fin_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // move on to the next channel or wrap up the tick
      if (ch_done) begin
         if (ch_ff == CH_W'(NUM_CH - 1)) begin
            if (idx_ff >= total_ff) begin
               active_in = 1'b0;
               fin_in    = 1'b1;
            end
            state_in = ST_OUT;
         end else begin
            ch_in    = ch_ff + 1'b1;
            state_in = ST_MUL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int k = 0; k < NUM_CH; k++) begin
            servo_ff[k] <= RESET_ANGLE;
         end
         enable_ff    <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         active_ff    <= 1'b0;
         fin_ff       <= 1'b0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         servo_ff     <= servo_in;
         enable_ff    <= enable_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         fin_ff       <= fin_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff      <= start_in;
      goal_ff       <= goal_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      rsp_angle_ff  <= rsp_angle_in;
      rsp_moving_ff <= rsp_moving_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   // new requests only while the sequencer is idle
   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_angle_shoulder = rsp_angle_ff[CH_SHOULDER];
   assign rsp_angle_elbow    = rsp_angle_ff[CH_ELBOW];
   assign rsp_angle_wrist    = rsp_angle_ff[CH_WRIST];
   assign rsp_angle_grip     = rsp_angle_ff[CH_GRIP];
   assign rsp_moving         = rsp_moving_ff;
   assign rsp_finished       = rsp_fin_ff;

endmodule
